// ===== hdl/tvns_pkg.sv =====
// Package for the triangle vertex normal scatter block: request and result
// structs, command codes, state enums and datapath widths.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package tvns_pkg;

  // Sizes of the block's fields and of the normalisation datapath.
  localparam int VERTEX_COUNT_DEF = 1024;
  localparam int IDX_W    = 10;
  localparam int COORD_W  = 24;
  localparam int NORM_W   = 16;
  localparam int DIFF_W   = 25;
  localparam int MUL_W    = 31;
  localparam int PROD_W   = 62;
  localparam int CROSS_W  = 52;
  localparam int SUM_W    = 62;
  localparam int ROOT_W   = 31;
  localparam int REM_W    = 33;
  localparam int NUM_W    = 46;
  localparam int FRAC_W   = 15;
  localparam int CNT_W    = 6;

  // Command codes.
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_FACE = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
  localparam logic [1:0] CMD_RSVD = 2'd3;

  // Largest Q1.15 value, used for the reset normal and for saturation.
  localparam logic signed [NORM_W-1:0] NORM_ONE = 16'sd32767;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [IDX_W-1:0]          index_a;
    logic [IDX_W-1:0]          index_b;
    logic [IDX_W-1:0]          index_c;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } in_req_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
  } out_rsp_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic busy;
    logic done;
  } math_status_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_VRD0, ST_VRD1, ST_VRD2, ST_VRD3,
    ST_CALC, ST_WR0, ST_WR1, ST_WR2, ST_NRD
  } top_state_t;

  typedef enum logic [2:0] {
    M_IDLE, M_MUL, M_MAG, M_NORM, M_SQ, M_SQRT, M_DIV, M_DONE
  } math_state_t;

endpackage

`default_nettype wire

// ===== hdl/tvns_math.sv =====
// Face normal unit: cross product, normalising shift, square root and three
// divisions in sequence; the products and squares share one multiplier.
// Depends on tvns_pkg.
`default_nettype none

module tvns_math (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  input  tvns_pkg::vertex_t      v0,
  input  tvns_pkg::vertex_t      v1,
  input  tvns_pkg::vertex_t      v2,
  output tvns_pkg::math_status_t status,
  output tvns_pkg::out_rsp_t     normal
);

  localparam int DW = tvns_pkg::DIFF_W;
  localparam int MW = tvns_pkg::MUL_W;
  localparam int PW = tvns_pkg::PROD_W;
  localparam int CW = tvns_pkg::CROSS_W;
  localparam int SW = tvns_pkg::SUM_W;
  localparam int RW = tvns_pkg::ROOT_W;
  localparam int EW = tvns_pkg::REM_W;
  localparam int NW = tvns_pkg::NUM_W;
  localparam int FW = tvns_pkg::FRAC_W;
  localparam int OW = tvns_pkg::NORM_W;
  localparam int KW = tvns_pkg::CNT_W;

  tvns_pkg::math_state_t state_r, state_nxt;

  logic [KW-1:0]        cnt_r;
  logic signed [DW-1:0] d1_r [3];
  logic signed [DW-1:0] d2_r [3];
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_r;
  logic signed [CW-1:0] c_r [3];
  logic [2:0]           neg_r;
  logic [CW-1:0]        mag_r [3];
  logic [CW-1:0]        max_r;
  logic [SW-1:0]        sum_r;
  logic [EW-1:0]        rem_r;
  logic [RW-1:0]        root_r;
  logic [NW-1:0]        num_r, dvs_r;
  logic [OW-1:0]        quo_r;
  logic [1:0]           k_r;
  logic signed [OW-1:0] o_r [3];

  // Combinational helpers.
  logic [2:0]           pk;
  logic [CW-1:0]        mag_c [3];
  logic [CW-1:0]        max_c;
  logic [EW+1:0]        rem_t, trial;
  logic                 root_ge;
  logic                 div_ge;
  logic [OW-1:0]        quo_step;
  logic [OW-1:0]        quo_sat;
  logic [CW-1:0]        mag_k;
  logic                 neg_k;

  assign pk = cnt_r[2:0] - 3'd1;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tvns_pkg::M_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tvns_pkg::M_IDLE: if (start) state_nxt = tvns_pkg::M_MUL;
      tvns_pkg::M_MUL:  if (cnt_r == KW'(6)) state_nxt = tvns_pkg::M_MAG;
      tvns_pkg::M_MAG:  state_nxt = (max_c == '0) ? tvns_pkg::M_DONE : tvns_pkg::M_NORM;
      tvns_pkg::M_NORM: if (max_r[CW-1:30] == '0 && max_r[29]) state_nxt = tvns_pkg::M_SQ;
      tvns_pkg::M_SQ:   if (cnt_r == KW'(3)) state_nxt = tvns_pkg::M_SQRT;
      tvns_pkg::M_SQRT: if (cnt_r == KW'(RW - 1)) state_nxt = tvns_pkg::M_DIV;
      tvns_pkg::M_DIV:  if (cnt_r == KW'(OW) && k_r == 2'd2) state_nxt = tvns_pkg::M_DONE;
      tvns_pkg::M_DONE: state_nxt = tvns_pkg::M_IDLE;
      default:          state_nxt = tvns_pkg::M_IDLE;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      tvns_pkg::M_MUL: begin
        case (cnt_r[2:0])
          3'd0:    begin mul_a = MW'(d1_r[1]); mul_b = MW'(d2_r[2]); end
          3'd1:    begin mul_a = MW'(d1_r[2]); mul_b = MW'(d2_r[1]); end
          3'd2:    begin mul_a = MW'(d1_r[2]); mul_b = MW'(d2_r[0]); end
          3'd3:    begin mul_a = MW'(d1_r[0]); mul_b = MW'(d2_r[2]); end
          3'd4:    begin mul_a = MW'(d1_r[0]); mul_b = MW'(d2_r[1]); end
          3'd5:    begin mul_a = MW'(d1_r[1]); mul_b = MW'(d2_r[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      tvns_pkg::M_SQ: begin
        case (cnt_r[1:0])
          2'd0:    mul_a = $signed({1'b0, mag_r[0][29:0]});
          2'd1:    mul_a = $signed({1'b0, mag_r[1][29:0]});
          2'd2:    mul_a = $signed({1'b0, mag_r[2][29:0]});
          default: mul_a = '0;
        endcase
        mul_b = mul_a;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Magnitudes and their largest, registered in the magnitude state.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = c_r[i][CW-1] ? CW'(-c_r[i]) : CW'(c_r[i]);
    end
    max_c = mag_c[0];
    if (mag_c[1] > max_c) max_c = mag_c[1];
    if (mag_c[2] > max_c) max_c = mag_c[2];
  end

  // One step of the digit-by-digit square root.
  assign rem_t   = {rem_r, sum_r[SW-1:SW-2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign root_ge = (rem_t >= trial);

  // One step of the restoring division, then saturation and sign.
  assign div_ge   = (num_r >= dvs_r);
  assign quo_step = {quo_r[OW-2:0], div_ge};
  assign quo_sat  = quo_step[OW-1] ? OW'(tvns_pkg::NORM_ONE) : quo_step;

  always_comb begin
    case (k_r)
      2'd0:    begin mag_k = mag_r[0]; neg_k = neg_r[0]; end
      2'd1:    begin mag_k = mag_r[1]; neg_k = neg_r[1]; end
      default: begin mag_k = mag_r[2]; neg_k = neg_r[2]; end
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      tvns_pkg::M_IDLE: begin
        cnt_r   <= '0;
        d1_r[0] <= DW'(v0.x) - DW'(v1.x);
        d1_r[1] <= DW'(v0.y) - DW'(v1.y);
        d1_r[2] <= DW'(v0.z) - DW'(v1.z);
        d2_r[0] <= DW'(v0.x) - DW'(v2.x);
        d2_r[1] <= DW'(v0.y) - DW'(v2.y);
        d2_r[2] <= DW'(v0.z) - DW'(v2.z);
      end
      tvns_pkg::M_MUL: begin
        cnt_r <= cnt_r + KW'(1);
        // The product of the previous cycle goes into its cross component.
        if (cnt_r != '0) begin
          if (!pk[0]) begin
            c_r[pk[2:1]] <= CW'(prod_r);
          end else begin
            c_r[pk[2:1]] <= c_r[pk[2:1]] - CW'(prod_r);
          end
        end
      end
      tvns_pkg::M_MAG: begin
        for (int i = 0; i < 3; i++) begin
          mag_r[i] <= mag_c[i];
          neg_r[i] <= c_r[i][CW-1];
          o_r[i]   <= '0;
        end
        max_r <= max_c;
      end
      tvns_pkg::M_NORM: begin
        cnt_r <= '0;
        // Bring the largest magnitude into the range from 2^29 to 2^30.
        if (max_r[CW-1:30] != '0) begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
          max_r <= max_r >> 1;
        end else if (!max_r[29]) begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
          max_r <= max_r << 1;
        end
      end
      tvns_pkg::M_SQ: begin
        if (cnt_r == KW'(3)) begin
          cnt_r  <= '0;
          rem_r  <= '0;
          root_r <= '0;
        end else begin
          cnt_r <= cnt_r + KW'(1);
        end
        if (cnt_r == KW'(1)) begin
          sum_r <= SW'(prod_r);
        end else if (cnt_r != '0) begin
          sum_r <= sum_r + SW'(prod_r);
        end
      end
      tvns_pkg::M_SQRT: begin
        sum_r <= sum_r << 2;
        if (root_ge) begin
          rem_r  <= EW'(rem_t - trial);
          root_r <= {root_r[RW-2:0], 1'b1};
        end else begin
          rem_r  <= EW'(rem_t);
          root_r <= {root_r[RW-2:0], 1'b0};
        end
        if (cnt_r == KW'(RW - 1)) begin
          cnt_r <= '0;
          k_r   <= 2'd0;
        end else begin
          cnt_r <= cnt_r + KW'(1);
        end
      end
      tvns_pkg::M_DIV: begin
        if (cnt_r == '0) begin
          // Numerator is the magnitude in Q.15 plus half the root, for rounding.
          num_r <= {1'b0, mag_k[29:0], {FW{1'b0}}} + NW'(root_r >> 1);
          dvs_r <= {root_r, {FW{1'b0}}};
          quo_r <= '0;
          cnt_r <= KW'(1);
        end else begin
          if (div_ge) num_r <= num_r - dvs_r;
          dvs_r <= dvs_r >> 1;
          quo_r <= quo_step;
          if (cnt_r == KW'(OW)) begin
            o_r[k_r] <= neg_k ? -$signed(quo_sat) : $signed(quo_sat);
            k_r      <= k_r + 2'd1;
            cnt_r    <= '0;
          end else begin
            cnt_r <= cnt_r + KW'(1);
          end
        end
      end
      default: begin
        cnt_r <= '0;
      end
    endcase
  end

  assign status.busy = (state_r != tvns_pkg::M_IDLE);
  assign status.done = (state_r == tvns_pkg::M_DONE);
  assign normal.normal_x = o_r[0];
  assign normal.normal_y = o_r[1];
  assign normal.normal_z = o_r[2];

  // The square sum is only formed once the magnitudes are normalised.
  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tvns_pkg::M_SQ |-> (max_r[CW-1:30] == '0 && max_r[29]))
    else $error("square sum started on an unnormalised magnitude");

  // The root of a normalised sum is never below 2^29, so divisions are safe.
  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tvns_pkg::M_DIV |-> root_r[RW-1:RW-2] != 2'b00)
    else $error("divisor out of range");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    status.done |=> state_r == tvns_pkg::M_IDLE)
    else $error("unit did not return to idle after done");

endmodule

`default_nettype wire

// ===== hdl/triangle_vertex_normal_scatter.sv =====
// Top level of the triangle vertex normal scatter block: vertex and normal
// stores, request sequencer and result register. Depends on tvns_pkg and
// tvns_math.
//
//   channel  ports                          payload        direction
//   in       in_valid, in_ready, in_data    in_req_t       request in
//   out      out_valid, out_ready, out_data out_rsp_t      result out
//
// After reset the normal store is cleared to (1,0,0) one entry a cycle, with
// in_ready low until every entry is written. A load is written while idle; a
// read waits on out_ready. A face request runs three vertex reads, six
// products on the shared multiplier, up to 29 normalising shifts, three
// squares, 31 square root steps, three divisions and three normal writes; a
// zero cross product goes straight from the magnitudes to the normal writes.
// in_ready is high only when idle.
`default_nettype none

module triangle_vertex_normal_scatter #(
  parameter int VERTEX_COUNT = tvns_pkg::VERTEX_COUNT_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  tvns_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output tvns_pkg::out_rsp_t out_data
);

  localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam logic [31:0] VC = 32'(VERTEX_COUNT);

  tvns_pkg::top_state_t state_r, state_nxt;

  // Stores.
  tvns_pkg::vertex_t  vmem [VERTEX_COUNT];
  tvns_pkg::out_rsp_t nmem [VERTEX_COUNT];

  tvns_pkg::vertex_t  v_q_r, v0_r, v1_r, v_wdata;
  tvns_pkg::out_rsp_t n_q_r, n_wdata, out_data_r, math_normal;
  tvns_pkg::math_status_t math_status;

  logic          v_we, v_re, n_we, n_re, math_start, out_load;
  logic [AW-1:0] v_waddr, v_raddr, n_waddr, n_raddr;
  logic [AW-1:0] ia_r, ib_r, ic_r, clr_r;
  logic          zero_r, out_valid_r;
  logic          a_ok, b_ok, c_ok;

  assign a_ok = (32'(in_data.index_a) < VC);
  assign b_ok = (32'(in_data.index_b) < VC);
  assign c_ok = (32'(in_data.index_c) < VC);

  assign v_wdata.x = in_data.coord_x;
  assign v_wdata.y = in_data.coord_y;
  assign v_wdata.z = in_data.coord_z;
  assign v_waddr   = AW'(in_data.index_a);

  // Normal computation unit.
  tvns_math u_math (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (math_start),
    .v0     (v0_r),
    .v1     (v1_r),
    .v2     (v_q_r),
    .status (math_status),
    .normal (math_normal)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tvns_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and store controls.
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    v_we       = 1'b0;
    v_re       = 1'b0;
    v_raddr    = ia_r;
    n_we       = 1'b0;
    n_waddr    = clr_r;
    n_wdata    = {tvns_pkg::NORM_ONE, 16'sd0, 16'sd0};
    n_re       = 1'b0;
    n_raddr    = AW'(in_data.index_a);
    math_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      tvns_pkg::ST_CLEAR: begin
        n_we = 1'b1;
        if (clr_r == AW'(VERTEX_COUNT - 1)) state_nxt = tvns_pkg::ST_IDLE;
      end
      tvns_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_data.cmd)
            tvns_pkg::CMD_LOAD: v_we = a_ok;
            tvns_pkg::CMD_FACE: begin
              if (a_ok && b_ok && c_ok) state_nxt = tvns_pkg::ST_VRD0;
            end
            tvns_pkg::CMD_READ: begin
              n_re      = a_ok;
              state_nxt = tvns_pkg::ST_NRD;
            end
            default: state_nxt = tvns_pkg::ST_IDLE;
          endcase
        end
      end
      tvns_pkg::ST_VRD0: begin
        v_re      = 1'b1;
        v_raddr   = ia_r;
        state_nxt = tvns_pkg::ST_VRD1;
      end
      tvns_pkg::ST_VRD1: begin
        v_re      = 1'b1;
        v_raddr   = ib_r;
        state_nxt = tvns_pkg::ST_VRD2;
      end
      tvns_pkg::ST_VRD2: begin
        v_re      = 1'b1;
        v_raddr   = ic_r;
        state_nxt = tvns_pkg::ST_VRD3;
      end
      tvns_pkg::ST_VRD3: begin
        math_start = 1'b1;
        state_nxt  = tvns_pkg::ST_CALC;
      end
      tvns_pkg::ST_CALC: begin
        if (math_status.done) state_nxt = tvns_pkg::ST_WR0;
      end
      tvns_pkg::ST_WR0: begin
        n_we      = 1'b1;
        n_waddr   = ia_r;
        n_wdata   = math_normal;
        state_nxt = tvns_pkg::ST_WR1;
      end
      tvns_pkg::ST_WR1: begin
        n_we      = 1'b1;
        n_waddr   = ib_r;
        n_wdata   = math_normal;
        state_nxt = tvns_pkg::ST_WR2;
      end
      tvns_pkg::ST_WR2: begin
        n_we      = 1'b1;
        n_waddr   = ic_r;
        n_wdata   = math_normal;
        state_nxt = tvns_pkg::ST_IDLE;
      end
      tvns_pkg::ST_NRD: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = tvns_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tvns_pkg::ST_IDLE;
    endcase
  end

  // Vertex store.
  always_ff @(posedge clk) begin
    if (v_we) vmem[v_waddr] <= v_wdata;
    if (v_re) v_q_r <= vmem[v_raddr];
  end

  // Normal store.
  always_ff @(posedge clk) begin
    if (n_we) nmem[n_waddr] <= n_wdata;
    if (n_re) n_q_r <= nmem[n_raddr];
  end

  // Clearing counter, request capture and vertex holding registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (state_r == tvns_pkg::ST_CLEAR) begin
      clr_r <= clr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == tvns_pkg::ST_IDLE && in_valid) begin
      ia_r   <= AW'(in_data.index_a);
      ib_r   <= AW'(in_data.index_b);
      ic_r   <= AW'(in_data.index_c);
      zero_r <= !a_ok;
    end
    if (state_r == tvns_pkg::ST_VRD1) v0_r <= v_q_r;
    if (state_r == tvns_pkg::ST_VRD2) v1_r <= v_q_r;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= zero_r ? '0 : n_q_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    math_status.done |-> state_r == tvns_pkg::ST_CALC)
    else $error("normal unit finished outside the calculation state");

  a_busy_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    math_status.busy |-> state_r == tvns_pkg::ST_CALC)
    else $error("normal unit busy while the sequencer has moved on");

  a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.cmd == tvns_pkg::CMD_READ)
      |=> state_r == tvns_pkg::ST_NRD)
    else $error("read request did not enter the normal read state");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for the triangle vertex normal scatter block: directed table, then
// random load, face and read requests, checked against an in-bench normal predictor.
// Depends on tvns_pkg and the block's top level.
`default_nettype none

module tb_top;

  localparam int NVERT = 1024;
  localparam int CYCLE_LIMIT = 900000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tvns_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tvns_pkg::out_rsp_t out_data;

  triangle_vertex_normal_scatter i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: vertex coordinates, stored normals and a record of loads.
  logic signed [tvns_pkg::COORD_W-1:0] pos_x [NVERT];
  logic signed [tvns_pkg::COORD_W-1:0] pos_y [NVERT];
  logic signed [tvns_pkg::COORD_W-1:0] pos_z [NVERT];
  tvns_pkg::out_rsp_t normal_mem [NVERT];
  bit loaded [NVERT];
  tvns_pkg::out_rsp_t pending_normals [$];
  int mismatches = 0;
  int cycles = 0;
  bit hold_off = 1'b0;

  // Appends one expected normal at the tail of the queue.
  task automatic expect_normal(tvns_pkg::out_rsp_t n);
    pending_normals.insert(pending_normals.size(), n);
  endtask

  function automatic logic [63:0] root64(logic [63:0] s);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Unit face normal of three stored vertices, in Q1.15.
  function automatic tvns_pkg::out_rsp_t face_normal(int i0, int i1, int i2);
    longint d1x, d1y, d1z, d2x, d2y, d2z;
    longint c [3];
    logic [63:0] a [3];
    logic [63:0] m, s, r, q;
    int p;
    logic signed [tvns_pkg::NORM_W-1:0] o [3];
    d1x = longint'(pos_x[i0]) - longint'(pos_x[i1]);
    d1y = longint'(pos_y[i0]) - longint'(pos_y[i1]);
    d1z = longint'(pos_z[i0]) - longint'(pos_z[i1]);
    d2x = longint'(pos_x[i0]) - longint'(pos_x[i2]);
    d2y = longint'(pos_y[i0]) - longint'(pos_y[i2]);
    d2z = longint'(pos_z[i0]) - longint'(pos_z[i2]);
    c[0] = d1y * d2z - d1z * d2y;
    c[1] = d1z * d2x - d1x * d2z;
    c[2] = d1x * d2y - d1y * d2x;
    m = 0;
    for (int k = 0; k < 3; k++) begin
      a[k] = (c[k] < 0) ? 64'(-c[k]) : 64'(c[k]);
      if (a[k] > m) m = a[k];
    end
    if (m == 0) return '0;
    p = 63;
    while (m[p] == 1'b0) p--;
    for (int k = 0; k < 3; k++) begin
      if (p < 29) a[k] = a[k] << (29 - p);
      else if (p > 29) a[k] = a[k] >> (p - 29);
    end
    s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    r = root64(s);
    for (int k = 0; k < 3; k++) begin
      q = (a[k] * 64'd32768 + (r >> 1)) / r;
      if (q > 64'd32767) q = 64'd32767;
      o[k] = (c[k] < 0) ? -tvns_pkg::NORM_W'(q) : tvns_pkg::NORM_W'(q);
    end
    return '{normal_x: o[0], normal_y: o[1], normal_z: o[2]};
  endfunction

  // Applies one accepted request to the predictor and queues any read result.
  task automatic predict_request(tvns_pkg::in_req_t rq);
    tvns_pkg::out_rsp_t n;
    case (rq.cmd)
      tvns_pkg::CMD_LOAD: begin
        pos_x[rq.index_a] = rq.coord_x;
        pos_y[rq.index_a] = rq.coord_y;
        pos_z[rq.index_a] = rq.coord_z;
        loaded[rq.index_a] = 1'b1;
      end
      tvns_pkg::CMD_FACE: begin
        n = face_normal(rq.index_a, rq.index_b, rq.index_c);
        normal_mem[rq.index_a] = n;
        normal_mem[rq.index_b] = n;
        normal_mem[rq.index_c] = n;
      end
      tvns_pkg::CMD_READ: expect_normal(normal_mem[rq.index_a]);
      default: ;
    endcase
  endtask

  // Result monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    tvns_pkg::out_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = pending_normals.pop_front();
        if (out_data.normal_x !== want.normal_x || out_data.normal_y !== want.normal_y ||
            out_data.normal_z !== want.normal_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("normal mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                     want.normal_x, want.normal_y, want.normal_z,
                     out_data.normal_x, out_data.normal_y, out_data.normal_z);
        end
      end
    end
  end

  // Receiver: random stalls per result, plus one long hold-off when asked.
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (hold_off || gap > 0) out_ready <= 1'b0;
      while (hold_off) @(posedge clk);
      repeat (gap) @(posedge clk);
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
    end
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Sends one request and updates the predictor when it is taken; valid stays
  // high when the next request follows with no gap.
  task automatic send_request(tvns_pkg::in_req_t rq, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= rq;
    in_valid <= 1'b1;
    @(posedge clk iff in_ready);
    predict_request(rq);
  endtask

  function automatic tvns_pkg::in_req_t make_req(logic [1:0] cmd, int a, int b, int c,
                                                 int x, int y, int z);
    tvns_pkg::in_req_t rq;
    rq.cmd = cmd;
    rq.index_a = a[tvns_pkg::IDX_W-1:0];
    rq.index_b = b[tvns_pkg::IDX_W-1:0];
    rq.index_c = c[tvns_pkg::IDX_W-1:0];
    rq.coord_x = x[tvns_pkg::COORD_W-1:0];
    rq.coord_y = y[tvns_pkg::COORD_W-1:0];
    rq.coord_z = z[tvns_pkg::COORD_W-1:0];
    return rq;
  endfunction

  // Random request: mostly loaded-vertex faces and reads, a little noise.
  function automatic tvns_pkg::in_req_t random_req(int pool);
    int sel, a, b, c;
    tvns_pkg::in_req_t rq;
    sel = $urandom_range(0, 99);
    a = $urandom_range(0, pool - 1);
    b = $urandom_range(0, pool - 1);
    c = $urandom_range(0, pool - 1);
    rq = make_req(tvns_pkg::CMD_LOAD, a, b, c, $urandom, $urandom, $urandom);
    if (sel < 30) begin
      // Small coordinates sometimes, to exercise the up-shift path.
      if ($urandom_range(0, 2) == 0) begin
        rq.coord_x = $signed(8'($urandom));
        rq.coord_y = $signed(8'($urandom));
        rq.coord_z = $signed(8'($urandom));
      end
    end else if (sel < 55) begin
      rq.cmd = tvns_pkg::CMD_FACE;
      if (!loaded[a] || !loaded[b] || !loaded[c]) rq.index_a = 10'($urandom_range(0, 9));
      if (!loaded[rq.index_a] || !loaded[b] || !loaded[c]) begin
        rq.index_a = 0; rq.index_b = 1; rq.index_c = 2;
      end
      if ($urandom_range(0, 9) == 0) rq.index_b = rq.index_a;
    end else if (sel < 97) begin
      rq.cmd = tvns_pkg::CMD_READ;
      if ($urandom_range(0, 9) == 0) rq.index_a = 10'($urandom);
    end else begin
      rq.cmd = tvns_pkg::CMD_RSVD;
      rq.index_a = 10'($urandom);
    end
    return rq;
  endfunction

  // Directed table; for reads the expected normal is checked by the predictor.
  localparam int DIR_N = 18;
  tvns_pkg::in_req_t dir_table [DIR_N];

  initial begin
    tvns_pkg::out_rsp_t reset_normal;
    for (int i = 0; i < NVERT; i++) begin
      normal_mem[i] = '{normal_x: tvns_pkg::NORM_ONE, normal_y: 16'sd0, normal_z: 16'sd0};
      loaded[i] = 1'b0;
    end
    reset_normal = '{normal_x: 16'sd32767, normal_y: 16'sd0, normal_z: 16'sd0};
    dir_table = '{
      make_req(tvns_pkg::CMD_READ, 0, 0, 0, 0, 0, 0),
      make_req(tvns_pkg::CMD_READ, 1023, 0, 0, 0, 0, 0),
      make_req(tvns_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0),
      make_req(tvns_pkg::CMD_LOAD, 1, 0, 0, 256, 0, 0),
      make_req(tvns_pkg::CMD_LOAD, 2, 0, 0, 0, 256, 0),
      make_req(tvns_pkg::CMD_FACE, 0, 1, 2, 0, 0, 0),
      make_req(tvns_pkg::CMD_READ, 0, 0, 0, 0, 0, 0),
      make_req(tvns_pkg::CMD_LOAD, 3, 0, 0, 8388607, 8388607, 8388607),
      make_req(tvns_pkg::CMD_LOAD, 4, 0, 0, -8388608, -8388608, -8388608),
      make_req(tvns_pkg::CMD_LOAD, 1023, 1023, 1023, -8388608, 8388607, -8388608),
      make_req(tvns_pkg::CMD_FACE, 3, 4, 1023, 0, 0, 0),
      make_req(tvns_pkg::CMD_READ, 1023, 0, 0, 0, 0, 0),
      make_req(tvns_pkg::CMD_FACE, 3, 4, 4, 0, 0, 0),
      make_req(tvns_pkg::CMD_READ, 4, 0, 0, 0, 0, 0),
      make_req(tvns_pkg::CMD_RSVD, 1023, 1023, 1023, -1, -1, -1),
      make_req(tvns_pkg::CMD_FACE, 2, 1023, 0, 0, 0, 0),
      make_req(tvns_pkg::CMD_READ, 2, 0, 0, 0, 0, 0),
      make_req(tvns_pkg::CMD_READ, 3, 0, 0, 0, 0, 0)
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // After reset every normal reads as (1,0,0).
    send_request(dir_table[0], 0);
    pending_normals[pending_normals.size() - 1] = reset_normal;
    send_request(dir_table[1], 0);
    pending_normals[pending_normals.size() - 1] = reset_normal;
    for (int i = 2; i < DIR_N; i++) send_request(dir_table[i], $urandom_range(0, 2));
    // Pause until all results are in.
    in_valid <= 1'b0;
    @(posedge clk iff pending_normals.size() == 0);
    // Preload a pool of vertices so faces mostly use written entries.
    for (int i = 0; i < 32; i++)
      send_request(make_req(tvns_pkg::CMD_LOAD, i, 0, 0, $urandom, $urandom, $urandom), 0);
    for (int n = 0; n < 1100; n++) begin
      if (n == 300) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (400) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      if (n == 600) begin
        in_valid <= 1'b0;
        @(posedge clk iff pending_normals.size() == 0);
      end
      send_request(random_req(n < 700 ? 32 : 1024),
                   ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
    end
    in_valid <= 1'b0;
    @(posedge clk iff pending_normals.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_normals.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/tvns_pkg.sv
hdl/tvns_math.sv
hdl/triangle_vertex_normal_scatter.sv
test/tb_top.sv
